@@ rtl/assert_macros.svh @@
// Assertion wrappers, clocked with reset disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ rtl/sle_pkg.sv @@
package sle_pkg;

	localparam int SLE_DEPTH      = 64;
	localparam int SLE_DATA_WIDTH = 32;
	localparam int SLE_FUNC_W     = 3;
	localparam int SLE_IDX_W      = 7;
	localparam int SLE_WORD_W     = 32;
	localparam int SLE_LEN_W      = 7;

	localparam logic [SLE_FUNC_W-1:0] OP_GET    = 3'd0;
	localparam logic [SLE_FUNC_W-1:0] OP_SET    = 3'd1;
	localparam logic [SLE_FUNC_W-1:0] OP_INSERT = 3'd2;
	localparam logic [SLE_FUNC_W-1:0] OP_APPEND = 3'd3;
	localparam logic [SLE_FUNC_W-1:0] OP_REMOVE = 3'd4;
	localparam logic [SLE_FUNC_W-1:0] OP_CLEAR  = 3'd5;

	typedef struct packed {
		logic [SLE_FUNC_W-1:0] func;
		logic [SLE_IDX_W-1:0]  index;
		logic [SLE_WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                  ok;
		logic [SLE_WORD_W-1:0] data;
		logic [SLE_LEN_W-1:0]  length;
		logic                  empty_res;
	} rsp_t;

	// pointer update
	localparam logic [2:0] PTR_HOLD  = 3'd0;
	localparam logic [2:0] PTR_CNTM1 = 3'd1;
	localparam logic [2:0] PTR_IDX   = 3'd2;
	localparam logic [2:0] PTR_INC   = 3'd3;
	localparam logic [2:0] PTR_DEC   = 3'd4;

	// write address
	localparam logic [1:0] WA_IDX   = 2'd0;
	localparam logic [1:0] WA_CNT   = 2'd1;
	localparam logic [1:0] WA_PTRP1 = 2'd2;
	localparam logic [1:0] WA_PTRM1 = 2'd3;

	// write data
	localparam logic WD_VAL = 1'b0;
	localparam logic WD_RAM = 1'b1;

	// count update
	localparam logic [1:0] CNT_HOLD = 2'd0;
	localparam logic [1:0] CNT_INC  = 2'd1;
	localparam logic [1:0] CNT_DEC  = 2'd2;
	localparam logic [1:0] CNT_CLR  = 2'd3;

	typedef struct packed {
		logic       ld_req;
		logic [2:0] ptr_op;
		logic       re;
		logic       we;
		logic [1:0] wa_sel;
		logic       wd_sel;
		logic [1:0] cnt_op;
		logic       ok_set;
		logic       data_cap;
		logic       rsp_load;
	} cmd_t;

	typedef struct packed {
		logic [SLE_FUNC_W-1:0] func;
		logic                  idx_lt_cnt;
		logic                  idx_eq_cnt;
		logic                  not_full;
		logic                  cnt_zero;
		logic                  ptr_eq_idx;
		logic                  ptrp1_lt_cnt;
		logic                  rsp_free;
	} sts_t;

endpackage

@@ rtl/sle_ram.sv @@
module sle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sle_ctrl.sv @@
module sle_ctrl import sle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_GET  = 3'd2;
	localparam logic [2:0] ST_REM  = 3'd3;
	localparam logic [2:0] ST_SHDN = 3'd4;
	localparam logic [2:0] ST_SHUP = 3'd5;
	localparam logic [2:0] ST_INSW = 3'd6;
	localparam logic [2:0] ST_RESP = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.ptr_op   = PTR_HOLD;
		cmd.wa_sel   = WA_IDX;
		cmd.wd_sel   = WD_VAL;
		cmd.cnt_op   = CNT_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.ld_req = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_RESP;
				case (sts.func)
					OP_GET: begin
						if (sts.idx_lt_cnt) begin
							cmd.ptr_op = PTR_IDX;
							cmd.re     = 1'b1;
							state_d    = ST_GET;
						end
					end
					OP_SET: begin
						if (sts.idx_lt_cnt) begin
							cmd.we     = 1'b1;
							cmd.ok_set = 1'b1;
						end
					end
					OP_INSERT: begin
						if ((sts.idx_lt_cnt || sts.idx_eq_cnt) && sts.not_full) begin
							if (sts.idx_eq_cnt) begin
								cmd.we     = 1'b1;
								cmd.cnt_op = CNT_INC;
								cmd.ok_set = 1'b1;
							end else begin
								cmd.ptr_op = PTR_CNTM1;
								cmd.re     = 1'b1;
								state_d    = ST_SHUP;
							end
						end
					end
					OP_APPEND: begin
						if (sts.not_full) begin
							cmd.we     = 1'b1;
							cmd.wa_sel = WA_CNT;
							cmd.cnt_op = CNT_INC;
							cmd.ok_set = 1'b1;
						end
					end
					OP_REMOVE: begin
						if (sts.idx_lt_cnt) begin
							cmd.ptr_op = PTR_IDX;
							cmd.re     = 1'b1;
							state_d    = ST_REM;
						end
					end
					OP_CLEAR: begin
						cmd.cnt_op = CNT_CLR;
						cmd.ok_set = 1'b1;
					end
					default: begin
					end
				endcase
			end
			ST_GET: begin
				cmd.data_cap = 1'b1;
				cmd.ok_set   = 1'b1;
				state_d      = ST_RESP;
			end
			ST_REM: begin
				cmd.data_cap = 1'b1;
				if (sts.ptrp1_lt_cnt) begin
					cmd.ptr_op = PTR_INC;
					cmd.re     = 1'b1;
					state_d    = ST_SHDN;
				end else begin
					cmd.cnt_op = CNT_DEC;
					cmd.ok_set = 1'b1;
					state_d    = ST_RESP;
				end
			end
			ST_SHDN: begin
				cmd.we     = 1'b1;
				cmd.wa_sel = WA_PTRM1;
				cmd.wd_sel = WD_RAM;
				if (sts.ptrp1_lt_cnt) begin
					cmd.ptr_op = PTR_INC;
					cmd.re     = 1'b1;
				end else begin
					cmd.cnt_op = CNT_DEC;
					cmd.ok_set = 1'b1;
					state_d    = ST_RESP;
				end
			end
			ST_SHUP: begin
				cmd.we     = 1'b1;
				cmd.wa_sel = WA_PTRP1;
				cmd.wd_sel = WD_RAM;
				if (sts.ptr_eq_idx) begin
					state_d = ST_INSW;
				end else begin
					cmd.ptr_op = PTR_DEC;
					cmd.re     = 1'b1;
				end
			end
			ST_INSW: begin
				cmd.we     = 1'b1;
				cmd.cnt_op = CNT_INC;
				cmd.ok_set = 1'b1;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/sle_dp.sv @@
module sle_dp import sle_pkg::*; #(
	parameter int DEPTH      = SLE_DEPTH,
	parameter int DATA_WIDTH = SLE_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t rsp,
	output logic rsp_valid,
	input  logic rsp_ready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = (CW > SLE_IDX_W) ? CW : SLE_IDX_W;
	localparam int SW = (DATA_WIDTH < SLE_WORD_W) ? DATA_WIDTH : SLE_WORD_W;

	logic [SLE_FUNC_W-1:0] func_q;
	logic [IW-1:0]         idx_q;
	logic [SW-1:0]         val_q;
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         ptr_d;
	logic                  ok_q;
	logic [SW-1:0]         data_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;
	logic [SW-1:0] rdata;

	always_comb begin
		case (cmd.ptr_op)
			PTR_CNTM1: ptr_d = AW'(cnt_q - CW'(1));
			PTR_IDX:   ptr_d = idx_q[AW-1:0];
			PTR_INC:   ptr_d = ptr_q + AW'(1);
			PTR_DEC:   ptr_d = ptr_q - AW'(1);
			default:   ptr_d = ptr_q;
		endcase
	end

	always_comb begin
		case (cmd.wa_sel)
			WA_CNT:   waddr = cnt_q[AW-1:0];
			WA_PTRP1: waddr = ptr_q + AW'(1);
			WA_PTRM1: waddr = ptr_q - AW'(1);
			default:  waddr = idx_q[AW-1:0];
		endcase
	end

	assign wdata = (cmd.wd_sel == WD_RAM) ? rdata : val_q;

	sle_ram #(
		.WIDTH (SW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.re),
		.raddr (ptr_d),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: cnt_q <= cnt_q + CW'(1);
				CNT_DEC: cnt_q <= cnt_q - CW'(1);
				CNT_CLR: cnt_q <= '0;
				default: cnt_q <= cnt_q;
			endcase
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (cmd.ld_req) begin
			func_q <= req.func;
			idx_q  <= IW'(req.index);
			val_q  <= req.value[SW-1:0];
			ok_q   <= 1'b0;
			data_q <= '0;
		end else begin
			if (cmd.ok_set) begin
				ok_q <= 1'b1;
			end
			if (cmd.data_cap) begin
				data_q <= rdata;
			end
		end
		if (cmd.rsp_load) begin
			rsp_q.ok        <= ok_q;
			rsp_q.data      <= SLE_WORD_W'(data_q);
			rsp_q.length    <= SLE_LEN_W'(cnt_q);
			rsp_q.empty_res <= (cnt_q == '0);
		end
	end

	assign sts.func         = func_q;
	assign sts.idx_lt_cnt   = idx_q < IW'(cnt_q);
	assign sts.idx_eq_cnt   = idx_q == IW'(cnt_q);
	assign sts.not_full     = cnt_q != CW'(DEPTH);
	assign sts.cnt_zero     = cnt_q == '0;
	assign sts.ptr_eq_idx   = IW'(ptr_q) == idx_q;
	assign sts.ptrp1_lt_cnt = (CW'(ptr_q) + CW'(1)) < cnt_q;
	assign sts.rsp_free     = !rsp_valid_q || rsp_ready;

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ rtl/sequential_list_engine.sv @@
// Ordered list of up to DEPTH words held in one single-port-write, registered-read RAM,
// with a length count in flip-flops. One request is worked at a time; a result register
// sits on the response side, so a finished result may wait while the block returns to
// idle. Clear, set, append and insert at the end finish in the execute state; get adds a
// read state; remove at position i and insert at position i < length shift the entries
// behind position i. The shift loops move one entry per cycle through the RAM, which
// sets the cost of insert and remove. Rejected requests go from execute straight to
// the response state. Entry words come up undefined; no clearing pass runs after reset.
`include "assert_macros.svh"

module sequential_list_engine import sle_pkg::*; #(
	parameter int DEPTH      = SLE_DEPTH,
	parameter int DATA_WIDTH = SLE_DATA_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;

	sle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sle_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

	`ASSERT_PROP(a_load_free, clk, arst_n, cmd.rsp_load |-> sts.rsp_free)
	`ASSERT_PROP(a_one_item, clk, arst_n, (req_valid && req_ready) |=> !req_ready)
	`ASSERT_NEVER(a_cnt_ovf, clk, arst_n, (cmd.cnt_op == CNT_INC) && !sts.not_full)
	`ASSERT_NEVER(a_cnt_unf, clk, arst_n, (cmd.cnt_op == CNT_DEC) && sts.cnt_zero)

endmodule

@@ tb/sv/sequential_list_engine_check.sv @@
module sequential_list_engine_check
	import sle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [SLE_WORD_W-1:0] WORD_MASK = {SLE_WORD_W{1'b1}} >> (SLE_WORD_W - SLE_DATA_WIDTH);

	logic [SLE_WORD_W-1:0] list_words [SLE_DEPTH];
	logic [SLE_LEN_W-1:0]  list_fill;
	rsp_t                  predicted [$];
	rsp_t                  want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic rsp_t apply_request(req_t r);
		rsp_t                  res;
		logic [SLE_WORD_W-1:0] w;
		int                    i;
		res = '0;
		w   = r.value & WORD_MASK;
		case (r.func)
			OP_GET: begin
				if (r.index < list_fill) begin
					res.data = list_words[r.index];
					res.ok   = 1'b1;
				end
			end
			OP_SET: begin
				if (r.index < list_fill) begin
					list_words[r.index] = w;
					res.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				if (r.index <= list_fill && list_fill < SLE_DEPTH) begin
					for (i = list_fill; i > r.index; i--)
						list_words[i] = list_words[i-1];
					list_words[r.index] = w;
					list_fill++;
					res.ok = 1'b1;
				end
			end
			OP_APPEND: begin
				if (list_fill < SLE_DEPTH) begin
					list_words[list_fill] = w;
					list_fill++;
					res.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (r.index < list_fill) begin
					res.data = list_words[r.index];
					for (i = r.index; i + 1 < list_fill; i++)
						list_words[i] = list_words[i+1];
					list_fill--;
					res.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				list_fill = '0;
				res.ok    = 1'b1;
			end
			default: ;
		endcase
		res.length    = list_fill;
		res.empty_res = (list_fill == 0);
		return res;
	endfunction

	task automatic flag(string what, logic [SLE_WORD_W-1:0] exp_v, logic [SLE_WORD_W-1:0] act_v);
		$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
		errors = errors + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_fill = '0;
			predicted.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (predicted.size() == 0) begin
					$display("%0t: result with none expected, actual %h", $time, rsp);
					errors = errors + 1;
				end else begin
					want = predicted.pop_front();
					if (rsp.ok !== want.ok)
						flag("ok", SLE_WORD_W'(want.ok), SLE_WORD_W'(rsp.ok));
					if (rsp.data !== want.data)
						flag("data", want.data, rsp.data);
					if (rsp.length !== want.length)
						flag("length", SLE_WORD_W'(want.length), SLE_WORD_W'(rsp.length));
					if (rsp.empty_res !== want.empty_res)
						flag("empty_res", SLE_WORD_W'(want.empty_res),
							SLE_WORD_W'(rsp.empty_res));
				end
			end
			if (req_valid && req_ready)
				predicted.push_back(apply_request(req));
		end
		pending = predicted.size();
	end

endmodule

@@ tb/sv/sequential_list_engine_test.sv @@
module sequential_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sle_pkg::*;

	typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

	localparam logic [SLE_FUNC_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [SLE_FUNC_W-1:0] OP_SPARE7 = 3'd7;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        rsp_ready = 1'b0;
	req_t        req       = '0;
	logic        req_ready;
	logic        rsp_valid;
	rsp_t        rsp;
	int          errors;
	int          pending;
	int unsigned list_len  = 0;
	bit          quiet     = 1'b0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	sequential_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	sequential_list_engine_check check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	function automatic req_t mk(logic [SLE_FUNC_W-1:0] f, logic [SLE_IDX_W-1:0] i,
			logic [SLE_WORD_W-1:0] v);
		req_t r;
		r.func  = f;
		r.index = i;
		r.value = v;
		return r;
	endfunction

	// list length after r, used only to aim indexes
	function automatic int unsigned next_len(req_t r, int unsigned n);
		case (r.func)
			OP_INSERT: if (r.index <= n && n < SLE_DEPTH) return n + 1;
			OP_APPEND: if (n < SLE_DEPTH) return n + 1;
			OP_REMOVE: if (r.index < n) return n - 1;
			OP_CLEAR:  return 0;
			default: ;
		endcase
		return n;
	endfunction

	function automatic req_t random_request(mix_t mix, int unsigned n);
		req_t        r;
		int unsigned roll;
		int unsigned pick;
		roll = $urandom_range(0, 99);
		if (roll >= 98)
			r.func = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
		else if (roll == 97)
			r.func = OP_CLEAR;
		else case (mix)
			MIX_FILL:
				r.func = roll < 45 ? OP_APPEND : roll < 80 ? OP_INSERT : roll < 88 ? OP_GET :
					roll < 95 ? OP_SET : OP_REMOVE;
			MIX_DRAIN:
				r.func = roll < 50 ? OP_REMOVE : roll < 65 ? OP_GET : roll < 75 ? OP_SET :
					roll < 85 ? OP_INSERT : OP_APPEND;
			default:
				r.func = roll < 20 ? OP_GET : roll < 36 ? OP_SET : roll < 54 ? OP_INSERT :
					roll < 70 ? OP_APPEND : roll < 92 ? OP_REMOVE : OP_CLEAR;
		endcase
		pick = $urandom_range(0, 99);
		if (pick < 10)
			r.index = SLE_IDX_W'($urandom_range(0, 127));
		else if (pick < 16)
			r.index = SLE_IDX_W'(n);
		else if (r.func == OP_INSERT)
			r.index = SLE_IDX_W'($urandom_range(0, n));
		else
			r.index = (n == 0) ? '0 : SLE_IDX_W'($urandom_range(0, n - 1));
		pick = $urandom_range(0, 19);
		r.value = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom();
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the handshake
	task automatic send_request(req_t r);
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		list_len = next_len(r, list_len);
		@(negedge clk);
	endtask

	task automatic hold_off(int n);
		req_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	initial begin
		int stall;
		int run;
		stall = 0;
		run   = 0;
		forever begin
			@(negedge clk);
			if (quiet)
				rsp_ready <= 1'b1;
			else if (stall > 0) begin
				stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
				if (run > 0)
					run--;
				else begin
					stall = $urandom_range(1, 17);
					run   = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
						: $urandom_range(1, 20);
				end
			end
		end
	end

	initial begin
		#10ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		mix_t plan [5];
		int   plan_len [5];
		int   phase;
		int   k;
		plan     = '{MIX_FILL, MIX_ANY, MIX_DRAIN, MIX_FILL, MIX_ANY};
		plan_len = '{90, 50, 80, 100, 50};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty list, boundary indexes, both ends of the value range
		send_request(mk(OP_GET, 0, 32'h1));
		send_request(mk(OP_REMOVE, 0, 32'h0));
		send_request(mk(OP_SET, 0, '1));
		send_request(mk(OP_INSERT, 1, 32'h11));
		send_request(mk(OP_INSERT, 0, '1));
		send_request(mk(OP_APPEND, 64, 32'h0));
		send_request(mk(OP_INSERT, 2, 32'hA5A5_A5A5));
		send_request(mk(OP_INSERT, 1, 32'h5A5A_5A5A));
		send_request(mk(OP_INSERT, 64, 32'h77));
		for (k = 0; k < 4; k++)
			send_request(mk(OP_GET, SLE_IDX_W'(k), '0));
		send_request(mk(OP_SET, 3, 32'h1234_5678));
		send_request(mk(OP_GET, 4, '0));
		send_request(mk(OP_REMOVE, 4, '0));
		send_request(mk(OP_REMOVE, 1, '0));
		send_request(mk(OP_REMOVE, 2, '0));
		send_request(mk(OP_SPARE6, 0, 32'h55));
		send_request(mk(OP_SPARE7, 127, '1));
		send_request(mk(OP_GET, 127, '0));
		send_request(mk(OP_CLEAR, 0, '0));
		send_request(mk(OP_GET, 0, '0));

		for (phase = 0; phase < 5; phase++) begin
			if (phase == 4)
				quiet = 1'b1;
			for (k = 0; k < plan_len[phase]; k++) begin
				if (!quiet && $urandom_range(0, 3) == 0)
					hold_off($urandom_range(1, 17));
				send_request(random_request(plan[phase], list_len));
			end
			if (phase == 0) begin
				hold_off(1);
				while (pending != 0)
					@(negedge clk);
			end
		end

		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sle_pkg.sv
rtl/sle_ram.sv
rtl/sle_ctrl.sv
rtl/sle_dp.sv
rtl/sequential_list_engine.sv
tb/sv/sequential_list_engine_check.sv
tb/sv/sequential_list_engine_test.sv
